[sv/cfe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared widths, the frame length reset value and control/status structs for the COBS frame
// encoder.
// ----------------------------------------------------------------------------
package cfe_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 6;
	localparam logic [LEN_W-1:0] FRAME_LEN_RST = LEN_W'(4);

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit_code;
		logic emit_data;
		logic emit_delim;
		logic clear_group;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_zero;
		logic is_last;
		logic group_empty;
		logic data_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[sv/cfe_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_dpath
// Frame length register, frame position, group buffer memory with registered
// read, and the output word register.
// ----------------------------------------------------------------------------
module cfe_dpath #(
	parameter int unsigned MAX_FRAME = 62
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [cfe_pkg::LEN_W-1:0]    cfg_wr_data,
	input  wire  [cfe_pkg::BYTE_W-1:0]   data_byte,
	input  wire  cfe_pkg::cmd_t          cmd,
	output cfe_pkg::sts_t                sts,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cfe_pkg::BYTE_W-1:0]   out_byte,
	output logic                         frame_end
);
	import cfe_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FRAME + 1);
	localparam int unsigned AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;

	logic [LEN_W-1:0]  frame_len_q;
	logic [LEN_W-1:0]  pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_idx_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] grp_mem [MAX_FRAME];

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              frame_end_q;

	logic [LEN_W-1:0]  eff_len;
	logic [LEN_W:0]    pos_inc;
	logic              last;
	logic              wr_en;
	logic [CW-1:0]     nxt_idx;
	logic [AW-1:0]     rd_addr;
	logic              out_free;
	logic              load;

	always_comb begin
		if (frame_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (frame_len_q > LEN_W'(MAX_FRAME)) begin
			eff_len = LEN_W'(MAX_FRAME);
		end else begin
			eff_len = frame_len_q;
		end
	end

	assign pos_inc  = {1'b0, pos_q} + (LEN_W+1)'(1);
	assign last     = pos_inc >= {1'b0, eff_len};
	assign wr_en    = cmd.accept && (data_byte != '0) && (count_q < CW'(MAX_FRAME));
	assign out_free = !out_valid_q || !out_stall;
	assign load     = cmd.emit_code || cmd.emit_data || cmd.emit_delim;

	always_comb begin
		if (cmd.accept || cmd.clear_group) begin
			nxt_idx = '0;
		end else if (cmd.emit_data) begin
			nxt_idx = rd_idx_q + CW'(1);
		end else begin
			nxt_idx = rd_idx_q;
		end
		rd_addr = (nxt_idx < CW'(MAX_FRAME)) ? AW'(nxt_idx) : '0;
	end

	assign sts.is_zero     = data_byte == '0;
	assign sts.is_last     = last;
	assign sts.group_empty = count_q == '0;
	assign sts.data_last   = ({1'b0, rd_idx_q} + (CW+1)'(1)) == {1'b0, count_q};
	assign sts.out_free    = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q <= FRAME_LEN_RST;
			pos_q       <= '0;
			count_q     <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frame_len_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				pos_q <= last ? '0 : pos_inc[LEN_W-1:0];
			end
			if (cmd.clear_group) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			rd_idx_q <= nxt_idx;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			grp_mem[AW'(count_q)] <= data_byte;
		end
		rd_data_q <= grp_mem[rd_addr];
		if (cmd.emit_code) begin
			out_byte_q  <= BYTE_W'(count_q) + BYTE_W'(1);
			frame_end_q <= 1'b0;
		end else if (cmd.emit_data) begin
			out_byte_q  <= rd_data_q;
			frame_end_q <= 1'b0;
		end else if (cmd.emit_delim) begin
			out_byte_q  <= '0;
			frame_end_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME))
		else $error("group count above buffer depth");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_data |-> rd_idx_q < count_q)
		else $error("group read past its fill");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

[sv/cfe_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfe_ctrl
// Sequencer: takes one input word at a time and walks each group flush
// (code, data words) and the trailing delimiter.
// ----------------------------------------------------------------------------
module cfe_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  cfe_pkg::sts_t  sts,
	output cfe_pkg::cmd_t        cmd
);
	import cfe_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CODE  = 2'd1;
	localparam logic [1:0] ST_DATA  = 2'd2;
	localparam logic [1:0] ST_DELIM = 2'd3;

	logic [1:0] state_q, state_d;
	logic       more_q, more_d;
	logic       end_q, end_d;
	logic       flush_done;

	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		more_d     = more_q;
		end_d      = end_q;
		flush_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.is_zero) begin
						more_d  = sts.is_last;
						end_d   = sts.is_last;
						state_d = ST_CODE;
					end else if (sts.is_last) begin
						more_d  = 1'b0;
						end_d   = 1'b1;
						state_d = ST_CODE;
					end
				end
			end
			ST_CODE: begin
				if (sts.out_free) begin
					cmd.emit_code = 1'b1;
					if (sts.group_empty) begin
						cmd.clear_group = 1'b1;
						flush_done      = 1'b1;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (sts.out_free) begin
					cmd.emit_data = 1'b1;
					if (sts.data_last) begin
						cmd.clear_group = 1'b1;
						flush_done      = 1'b1;
					end
				end
			end
			ST_DELIM: begin
				if (sts.out_free) begin
					cmd.emit_delim = 1'b1;
					end_d          = 1'b0;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (flush_done) begin
			if (more_q) begin
				more_d  = 1'b0;
				state_d = ST_CODE;
			end else if (end_q) begin
				state_d = ST_DELIM;
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			more_q  <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
			end_q   <= end_d;
		end
	end

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.is_last) |=> state_q == ST_CODE && end_q)
		else $error("final word did not start the closing flush");

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_code, cmd.emit_data, cmd.emit_delim, cmd.accept}))
		else $error("conflicting datapath commands");

	a_more_implies_end: assert property (@(posedge clk) disable iff (!arst_n)
		more_q |-> end_q)
		else $error("second flush pending without delimiter");

endmodule

`default_nettype wire

[sv/cobs_frame_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_frame_encoder
// COBS encoder for fixed-length frames: stuffed bytes out, zero delimiter
// flagged with frame_end.
// ----------------------------------------------------------------------------
// One input word at a time. A nonzero byte that does not end the frame is
// accepted and in_stall stays low. A zero byte stalls the input while the
// open group drains through the output register: one code word plus one word
// per buffered byte, one per cycle while out_stall is low. The last byte of a
// frame adds the final group (code plus its bytes) and the delimiter; a zero
// as the last byte adds an empty group (code 1) before the delimiter. The
// drain rate is set by the single read port of the group buffer. frame_len
// is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// idle; the block itself does not enforce this. A frame_len of zero acts as 1
// and values above MAX_FRAME act as MAX_FRAME.
// ----------------------------------------------------------------------------
module cobs_frame_encoder #(
	parameter int unsigned MAX_FRAME = 62
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire  [cfe_pkg::LEN_W-1:0]    cfg_wr_data,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [cfe_pkg::BYTE_W-1:0]   data_byte,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [cfe_pkg::BYTE_W-1:0]   out_byte,
	output logic                         frame_end
);
	import cfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfe_dpath #(
		.MAX_FRAME (MAX_FRAME)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.frame_end   (frame_end)
	);

endmodule

`default_nettype wire
